// ----- rtl/pwr_pkg.sv -----
package pwr_pkg;

  // channel layout of one item
  localparam int unsigned ALL_LANES = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned PIXEL_W   = ALL_LANES * BYTE_W;

  // mean arithmetic
  localparam int          BYTE_BIAS = 128;
  localparam int          BYTE_MAX  = 255;
  localparam int unsigned Q_SHIFT   = 16;
  localparam int unsigned FACTOR_W  = 17;

  // stream packing
  localparam int unsigned IN_FIELDS_W = PIXEL_W + FACTOR_W;
  localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // parameter defaults
  localparam int unsigned DEF_LANES      = 16;
  localparam int unsigned DEF_MAX_WINDOW = 256;

  typedef enum logic {
    MODE_MAX  = 1'b0,
    MODE_MEAN = 1'b1
  } pool_mode_e;

  // per-cycle control from the top level to every lane
  typedef struct packed {
    logic       upd;       // accumulate the staged pixel
    logic       open;      // window already holds a pixel
    pool_mode_e mode;      // combine rule for this pixel
    logic       snap_en;   // window closes: capture the final accumulator
    logic       out_en;    // load the result byte register
    pool_mode_e out_mode;  // readout rule for the captured window
  } pwr_ctrl_t;

endpackage

// ----- rtl/pwr_lane.sv -----
module pwr_lane import pwr_pkg::*; #(
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int unsigned ACC_W      = 16
) (
  input  logic                clk_i,
  input  pwr_ctrl_t           ctrl_i,
  input  logic [BYTE_W-1:0]   byte_i,
  input  logic [FACTOR_W-1:0] factor_i,
  output logic [BYTE_W-1:0]   byte_o
);

  localparam int unsigned EXT_W  = ACC_W + 1;
  localparam int unsigned PROD_W = ACC_W + FACTOR_W + 1;
  localparam logic signed [EXT_W-1:0] SUM_LO = EXT_W'(-(BYTE_BIAS * int'(MAX_WINDOW)));
  localparam logic signed [EXT_W-1:0] SUM_HI = EXT_W'((BYTE_BIAS - 1) * int'(MAX_WINDOW));

  logic signed [ACC_W-1:0]  acc_q, acc_d, snap_q;
  logic signed [EXT_W-1:0]  byte_s, bias_s, acc_s, sum_s, mean_v, max_v;
  logic signed [PROD_W-1:0] prod_s, mean_t, sel_s;
  logic        [BYTE_W-1:0] res_q, res_d;

  // accumulate
  always_comb begin
    byte_s = $signed({{(EXT_W-BYTE_W){1'b0}}, byte_i});
    bias_s = byte_s - EXT_W'(BYTE_BIAS);
    acc_s  = EXT_W'(acc_q);
    sum_s  = acc_s + bias_s;
    if (!ctrl_i.open) begin
      mean_v = bias_s;
    end else if (sum_s < SUM_LO) begin
      mean_v = SUM_LO;
    end else if (sum_s > SUM_HI) begin
      mean_v = SUM_HI;
    end else begin
      mean_v = sum_s;
    end
    max_v = (ctrl_i.open && (acc_s > byte_s)) ? acc_s : byte_s;
    acc_d = (ctrl_i.mode == MODE_MEAN) ? mean_v[ACC_W-1:0] : max_v[ACC_W-1:0];
  end

  // readout: mean = floor(sum*factor/2^16)+128; max as is; byte clamp
  always_comb begin
    prod_s = PROD_W'(snap_q) * PROD_W'($signed({1'b0, factor_i}));
    mean_t = (prod_s >>> Q_SHIFT) + PROD_W'(BYTE_BIAS);
    sel_s  = (ctrl_i.out_mode == MODE_MEAN) ? mean_t : PROD_W'(snap_q);
    if (sel_s < 0) begin
      res_d = '0;
    end else if (sel_s > PROD_W'(BYTE_MAX)) begin
      res_d = BYTE_W'(BYTE_MAX);
    end else begin
      res_d = sel_s[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.snap_en) begin
      snap_q <= acc_d;
    end
    if (ctrl_i.out_en) begin
      res_q <= res_d;
    end
  end

  assign byte_o = res_q;

endmodule

// ----- rtl/pool_window_reducer_u8x16_top.sv -----
// uint8 window pooling over 16 channels. each input item is one pixel of 16
// bytes (pixel_lo = channels 0..7, pixel_hi = channels 8..15, channel 0 in the
// lowest byte); the item with tlast closes the window and yields one result
// item, other items yield nothing. pool_mode (cfg_we_i/cfg_wdata_i, write only
// while idle) picks max (0) or mean (1). mean gives per channel
// clamp(floor(sum(byte - 128) * mean_factor / 65536) + 128, 0..255), where
// mean_factor is the Q16 reciprocal of the window size taken from the closing
// item; lane sums saturate at -128*MAX_WINDOW..127*MAX_WINDOW. channels at or
// above LANES read as zero. one item is accepted per clock while no closing
// item waits in the input register for stage 2 to free up; a pixel is
// combined into the lane accumulators from the input register, and a closing
// item's result moves from the input register (loaded at acceptance) to the
// accumulator/capture register, then the multiply-and-clamp result register.
// the stages stall independently, so non-closing items keep flowing while a
// result waits on m_axis_tready.
module pool_window_reducer_u8x16_top import pwr_pkg::*; #(
  parameter int unsigned LANES      = DEF_LANES,
  parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration: pool_mode
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  // pixel stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,   // pixel_lo, pixel_hi, mean_factor, zero pad
  input  logic                 s_axis_tlast,   // last pixel of the window
  // pooled result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIXEL_W-1:0]   m_axis_tdata    // result_lo, result_hi
);

  // lane accumulator width: holds the saturated sum and a raw byte
  localparam int unsigned SUM_W = $clog2(MAX_WINDOW) + BYTE_W;
  localparam int unsigned ACC_W = (SUM_W < BYTE_W + 1) ? BYTE_W + 1 : SUM_W;

  pool_mode_e mode_q;

  // stage 1: input register
  logic                v1_q;
  logic [PIXEL_W-1:0]  pix1_q;
  logic                last1_q;
  logic [FACTOR_W-1:0] fac1_q;

  // stage 2: closed window waiting for readout
  logic                v2_q;
  pool_mode_e          mode2_q;
  logic [FACTOR_W-1:0] fac2_q;

  // stage 3: result register
  logic                v3_q;

  logic                open_q;
  logic                r1, r2, r3, c1, c2;
  pwr_ctrl_t           ctrl;
  logic [PIXEL_W-1:0]  res_all;

  // per-stage ready; a non-closing pixel retires without needing stage 2
  assign r3 = !v3_q || m_axis_tready;
  assign c2 = v2_q && r3;
  assign r2 = !v2_q || r3;
  assign c1 = v1_q && (!last1_q || r2);
  assign r1 = !v1_q || c1;

  assign s_axis_tready = r1;

  always_comb begin
    ctrl.upd      = c1;
    ctrl.open     = open_q;
    ctrl.mode     = mode_q;
    ctrl.snap_en  = c1 && last1_q;
    ctrl.out_en   = c2;
    ctrl.out_mode = mode2_q;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MAX;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      open_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= pool_mode_e'(cfg_wdata_i);
      end
      if (r1) begin
        v1_q <= s_axis_tvalid;
      end
      if (c1) begin
        open_q <= !last1_q;
      end
      if (ctrl.snap_en) begin
        v2_q <= 1'b1;
      end else if (c2) begin
        v2_q <= 1'b0;
      end
      if (c2) begin
        v3_q <= 1'b1;
      end else if (m_axis_tready) begin
        v3_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (r1 && s_axis_tvalid) begin
      pix1_q  <= s_axis_tdata[PIXEL_W-1:0];
      fac1_q  <= s_axis_tdata[IN_FIELDS_W-1:PIXEL_W];
      last1_q <= s_axis_tlast;
    end
    if (ctrl.snap_en) begin
      fac2_q  <= fac1_q;
      mode2_q <= mode_q;
    end
  end

  for (genvar g = 0; g < ALL_LANES; g++) begin : g_lane
    if (g < LANES) begin : g_on
      pwr_lane #(
        .MAX_WINDOW (MAX_WINDOW),
        .ACC_W      (ACC_W)
      ) u_lane (
        .clk_i    (clk_i),
        .ctrl_i   (ctrl),
        .byte_i   (pix1_q[g*BYTE_W +: BYTE_W]),
        .factor_i (fac2_q),
        .byte_o   (res_all[g*BYTE_W +: BYTE_W])
      );
    end else begin : g_off
      // channel beyond LANES: no hardware, reads as zero
      assign res_all[g*BYTE_W +: BYTE_W] = '0;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = res_all;

endmodule

// ----- rtl/pwr_checker.sv -----
module pwr_checker import pwr_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               s_axis_tlast,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [PIXEL_W-1:0] m_axis_tdata
);

  // windows closed at the input and not yet delivered
  logic [2:0] pend_q;
  logic       in_close, out_take;

  assign in_close = s_axis_tvalid && s_axis_tready && s_axis_tlast;
  assign out_take = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_close && !out_take) begin
      pend_q <= pend_q + 3'd1;
    end else if (out_take && !in_close) begin
      pend_q <= pend_q - 3'd1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result without a closed window");

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more windows in flight than pipeline stages");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 3'd0 |-> s_axis_tready)
    else $error("input stalled with no window in flight");

endmodule

bind pool_window_reducer_u8x16_top pwr_checker u_pwr_checker (.*);
